// File: rtl/core/rgbasb_pkg.sv
// Shared types and constants for the RGB565 alpha/shade blend pipeline.
package rgbasb_pkg;

   localparam int PIXEL_WIDTH     = 16;
   localparam int OPACITY_WIDTH   = 7;
   localparam int SHADE_WIDTH     = 6;
   localparam int ALPHA_WIDTH     = 6;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam int ALPHA_FULL = 32;
   localparam int PCT_FULL   = 100;

   // alpha = opacity * 32 / 100 as a multiply by a scaled reciprocal
   localparam int RECIP_SHIFT      = 15;
   localparam int ALPHA_RECIP      = ((ALPHA_FULL << RECIP_SHIFT) + PCT_FULL - 1) / PCT_FULL;
   localparam int ALPHA_PROD_WIDTH = OPACITY_WIDTH + RECIP_SHIFT - 1;

   localparam logic [PIXEL_WIDTH-1:0] KEY_COLOR_RESET = 16'hF81F;

   // Shade divider: 6 quotient bits, two restoring steps per stage
   localparam int DIV_WIDTH       = 6;
   localparam int DIV_STAGES      = 3;
   localparam int DIV_STEPS       = DIV_WIDTH / DIV_STAGES;
   localparam int LANES           = 3;
   localparam int LANE_BLUE       = 0;
   localparam int LANE_GREEN      = 1;
   localparam int LANE_RED        = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OPACITY    = 4'd0,
      CSR_SHADE      = 4'd1,
      CSR_KEY_ENABLE = 4'd2,
      CSR_KEY_COLOR  = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIV_WIDTH-1:0] rem;
      logic [DIV_WIDTH-1:0] nq;   // dividend bits shift out, quotient bits shift in
   } div_lane_type;

   typedef struct packed {
      logic                             keyed;
      logic [PIXEL_WIDTH-1:0]           src;
      logic [PIXEL_WIDTH-1:0]           dst;
      div_lane_type [LANES-1:0]         lane;
   } stage_type;

endpackage

// File: rtl/core/rgb565_alpha_shade_blend.sv
// Top level of the RGB565 color-key, shade and alpha blend pipeline.
//
// Requests arrive on req_ (source and destination pixel), results leave on
// rsp_ (output pixel and written flag), one result per request, in order.
// Registers are written through csr_ (index, data); csr_ready is always high.
// Index 0 opacity (percent, saturates at 100), 1 shade, 2 key enable,
// 3 key color; other indexes are ignored. Write only while the pipe is empty.
// A request goes from accept to rsp_valid through the input register, three
// divider stages of two restoring steps each, and the blend/output register.
// One pixel per clock while rsp_ready is high; divider lanes fully pipelined.
// Each stage holds its data while the one after it is full and stalled, so a
// low rsp_ready backs up the pipe stage by stage and bubbles are squeezed out.
// Reset empties the pipe and loads opacity 100, shade 0, key enabled,
// key color 0xF81F.
module rgb565_alpha_shade_blend import rgbasb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PIXEL_WIDTH-1:0]     req_src_pixel,
   input  logic [PIXEL_WIDTH-1:0]     req_dst_pixel,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PIXEL_WIDTH-1:0]     rsp_out_pixel,
   output logic                       rsp_written
);

   logic [ALPHA_WIDTH-1:0]      alpha_ff, alpha_in;
   logic [SHADE_WIDTH-1:0]      shade_ff, shade_in;
   logic                        key_enable_ff, key_enable_in;
   logic [PIXEL_WIDTH-1:0]      key_color_ff, key_color_in;
   logic [OPACITY_WIDTH-1:0]    opacity_sat;
   logic [ALPHA_PROD_WIDTH-1:0] alpha_prod;

   logic      head_valid_ff;
   stage_type head_data_ff, head_data_in;
   logic      head_ready;

   logic      chain_valid [0:DIV_STAGES];
   logic      chain_ready [0:DIV_STAGES];
   stage_type chain_data  [0:DIV_STAGES];

   logic                   out_valid_ff;
   logic [PIXEL_WIDTH-1:0] out_pixel_ff, out_pixel_in;
   logic                   written_ff, written_in;

   stage_type              tail;
   logic                   shade_bypass;
   logic [4:0]             fg_r, fg_b, bg_r, bg_b;
   logic [5:0]             fg_g, bg_g;
   logic [ALPHA_WIDTH-1:0] inv_alpha;
   logic [11:0]            sum_r, sum_g, sum_b;

   // Configuration
   assign csr_ready = 1'b1;

   always_comb begin
      opacity_sat = (csr_data[OPACITY_WIDTH-1:0] > OPACITY_WIDTH'(PCT_FULL)) ?
                    OPACITY_WIDTH'(PCT_FULL) : csr_data[OPACITY_WIDTH-1:0];
      alpha_prod  = ALPHA_PROD_WIDTH'(opacity_sat) * ALPHA_PROD_WIDTH'(ALPHA_RECIP);
      alpha_in      = alpha_ff;
      shade_in      = shade_ff;
      key_enable_in = key_enable_ff;
      key_color_in  = key_color_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OPACITY:    alpha_in      = alpha_prod[RECIP_SHIFT +: ALPHA_WIDTH];
            CSR_SHADE:      shade_in      = csr_data[SHADE_WIDTH-1:0];
            CSR_KEY_ENABLE: key_enable_in = csr_data[0];
            CSR_KEY_COLOR:  key_color_in  = csr_data[PIXEL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff      <= ALPHA_WIDTH'(ALPHA_FULL);
         shade_ff      <= '0;
         key_enable_ff <= 1'b1;
         key_color_ff  <= KEY_COLOR_RESET;
      end else begin
         alpha_ff      <= alpha_in;
         shade_ff      <= shade_in;
         key_enable_ff <= key_enable_in;
         key_color_ff  <= key_color_in;
      end
   end

   // Input register: key compare and divider lane setup
   always_comb begin
      head_data_in.keyed = key_enable_ff && (req_src_pixel == key_color_ff);
      head_data_in.src   = req_src_pixel;
      head_data_in.dst   = req_dst_pixel;
      head_data_in.lane[LANE_RED].rem   = '0;
      head_data_in.lane[LANE_RED].nq    = {1'b0, req_src_pixel[15:11]};
      head_data_in.lane[LANE_GREEN].rem = '0;
      head_data_in.lane[LANE_GREEN].nq  = req_src_pixel[10:5];
      head_data_in.lane[LANE_BLUE].rem  = '0;
      head_data_in.lane[LANE_BLUE].nq   = {1'b0, req_src_pixel[4:0]};
   end

   assign head_ready = !head_valid_ff || chain_ready[0];
   assign req_ready  = head_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else if (head_ready) begin
         head_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (head_ready && req_valid) begin
         head_data_ff <= head_data_in;
      end
   end

   assign chain_valid[0] = head_valid_ff;
   assign chain_data[0]  = head_data_ff;

   // Shade divider stages
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      rgbasb_div_stage u_div (
         .clock    (clock),
         .reset    (reset),
         .shade    (shade_ff),
         .up_valid (chain_valid[k]),
         .up_ready (chain_ready[k]),
         .up_data  (chain_data[k]),
         .dn_valid (chain_valid[k+1]),
         .dn_ready (chain_ready[k+1]),
         .dn_data  (chain_data[k+1])
      );
   end

   // Blend and output register
   assign tail         = chain_data[DIV_STAGES];
   assign shade_bypass = shade_ff <= SHADE_WIDTH'(1);

   always_comb begin
      if (shade_bypass) begin
         fg_r = tail.src[15:11];
         fg_g = tail.src[10:5];
         fg_b = tail.src[4:0];
      end else begin
         fg_r = tail.lane[LANE_RED].nq[4:0];
         fg_g = tail.lane[LANE_GREEN].nq;
         fg_b = tail.lane[LANE_BLUE].nq[4:0];
      end
      bg_r      = tail.dst[15:11];
      bg_g      = tail.dst[10:5];
      bg_b      = tail.dst[4:0];
      inv_alpha = ALPHA_WIDTH'(ALPHA_FULL) - alpha_ff;
      sum_r = 12'(fg_r) * 12'(alpha_ff) + 12'(bg_r) * 12'(inv_alpha);
      sum_g = 12'(fg_g) * 12'(alpha_ff) + 12'(bg_g) * 12'(inv_alpha);
      sum_b = 12'(fg_b) * 12'(alpha_ff) + 12'(bg_b) * 12'(inv_alpha);
      out_pixel_in = tail.keyed ? tail.dst : {sum_r[9:5], sum_g[10:5], sum_b[9:5]};
      written_in   = !tail.keyed;
   end

   assign chain_ready[DIV_STAGES] = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (chain_ready[DIV_STAGES]) begin
         out_valid_ff <= chain_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[DIV_STAGES] && chain_valid[DIV_STAGES]) begin
         out_pixel_ff <= out_pixel_in;
         written_ff   <= written_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_pixel = out_pixel_ff;
   assign rsp_written   = written_ff;

   // Checks
   a_key_flag: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff && head_data_ff.keyed |->
         key_enable_ff && (head_data_ff.src == key_color_ff))
      else $error("keyed flag disagrees with key registers");

   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      chain_valid[DIV_STAGES] && !chain_ready[DIV_STAGES] |=>
         chain_valid[DIV_STAGES] && $stable(chain_data[DIV_STAGES]))
      else $error("last divider stage lost data under stall");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(chain_valid[DIV_STAGES]))
      else $error("response appeared without a divider result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !head_valid_ff && !out_valid_ff)
      else $error("pipe not empty after reset");

endmodule

// File: rtl/core/rgbasb_div_stage.sv
// One pipeline stage of the shade divider: two restoring steps on each color lane.
module rgbasb_div_stage import rgbasb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SHADE_WIDTH-1:0] shade,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  stage_type              up_data,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output stage_type              dn_data
);

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   function automatic div_lane_type div_step(div_lane_type l, logic [SHADE_WIDTH-1:0] d);
      logic [DIV_WIDTH:0] trial;
      logic               ge;
      div_lane_type       r;
      trial = {l.rem, l.nq[DIV_WIDTH-1]};
      ge    = trial >= {1'b0, d};
      r.rem = ge ? DIV_WIDTH'(trial - {1'b0, d}) : trial[DIV_WIDTH-1:0];
      r.nq  = {l.nq[DIV_WIDTH-2:0], ge};
      return r;
   endfunction

   always_comb begin
      data_in = up_data;
      for (int i = 0; i < LANES; i++) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            data_in.lane[i] = div_step(data_in.lane[i], shade);
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: bench/tb_rgb565_alpha_shade_blend.sv
// Self-checking testbench for the RGB565 key, shade and alpha blend pipeline.
`timescale 1ns / 1ps

module tb_rgb565_alpha_shade_blend;
   import rgbasb_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int RANDOM_PHASES  = 12;
   localparam int ITEMS_PER_PHASE = 33;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST = CSR_KEY_COLOR;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOP  = '1;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] src;
      logic [PIXEL_WIDTH-1:0] dst;
   } pixel_pair_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   written;
   } blend_result_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } reg_write_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [PIXEL_WIDTH-1:0]     req_src_pixel = '0;
   logic [PIXEL_WIDTH-1:0]     req_dst_pixel = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [PIXEL_WIDTH-1:0]     rsp_out_pixel;
   logic                       rsp_written;

   // mirror of the block's registers
   logic [OPACITY_WIDTH-1:0]   opacity_q = 7'd100;
   logic [SHADE_WIDTH-1:0]     shade_q = '0;
   logic                       key_enable_q = 1'b1;
   logic [PIXEL_WIDTH-1:0]     key_color_q = KEY_COLOR_RESET;

   pixel_pair_type   pixel_q[$];
   blend_result_type blend_q[$];
   pixel_pair_type   next_pair;
   blend_result_type got_result;
   blend_result_type want_result;
   int            in_flight = 0;
   int            error_count = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 32;
   int            recv_idle_pct = 58;

   rgb565_alpha_shade_blend u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_src_pixel (req_src_pixel),
      .req_dst_pixel (req_dst_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_written   (rsp_written)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rgb565_alpha_shade_blend regression: fail");
         $finish;
      end
   end

   function automatic logic [PIXEL_WIDTH-1:0] shade_source(input logic [PIXEL_WIDTH-1:0] px);
      int r, g, b;
      if (shade_q <= 1)
         return px;
      r = int'(px[15:11]) / int'(shade_q);
      g = int'(px[10:5]) / int'(shade_q);
      b = int'(px[4:0]) / int'(shade_q);
      return {r[4:0], g[5:0], b[4:0]};
   endfunction

   function automatic logic [PIXEL_WIDTH-1:0] mix_lanes(input logic [PIXEL_WIDTH-1:0] bg,
                                                        input logic [PIXEL_WIDTH-1:0] fg,
                                                        input int alpha);
      int rb, g;
      if (alpha >= ALPHA_FULL)
         return fg;
      if (alpha == 0)
         return bg;
      rb = ((int'(fg & 16'hF81F) * alpha) + (int'(bg & 16'hF81F) * (ALPHA_FULL - alpha))) >> 5;
      g = ((int'(fg & 16'h07E0) * alpha) + (int'(bg & 16'h07E0) * (ALPHA_FULL - alpha))) >> 5;
      return (rb[15:0] & 16'hF81F) | (g[15:0] & 16'h07E0);
   endfunction

   function automatic blend_result_type compute_blend(input logic [PIXEL_WIDTH-1:0] src,
                                                      input logic [PIXEL_WIDTH-1:0] dst);
      blend_result_type res;
      int alpha;
      if (key_enable_q && src == key_color_q) begin
         res.pixel = dst;
         res.written = 1'b0;
         return res;
      end
      alpha = (int'(opacity_q) * ALPHA_FULL) / PCT_FULL;
      if (alpha > ALPHA_FULL)
         alpha = ALPHA_FULL;
      res.pixel = mix_lanes(dst, shade_source(src), alpha);
      res.written = 1'b1;
      return res;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                                     input logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         CSR_OPACITY: begin
            opacity_q = (data[6:0] > PCT_FULL) ? 7'(PCT_FULL) : data[6:0];
         end
         CSR_SHADE: begin
            shade_q = data[5:0];
         end
         CSR_KEY_ENABLE: begin
            key_enable_q = data[0];
         end
         CSR_KEY_COLOR: begin
            key_color_q = data;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [PIXEL_WIDTH-1:0] got,
                                  input logic [PIXEL_WIDTH-1:0] want);
      $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            blend_q.push_back(compute_blend(req_src_pixel, req_dst_pixel));
         if (!req_valid || req_ready) begin
            if (pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_pair = pixel_q.pop_front();
               in_flight++;
               req_src_pixel <= next_pair.src;
               req_dst_pixel <= next_pair.dst;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         got_result.pixel = rsp_out_pixel;
         got_result.written = rsp_written;
         if (blend_q.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_out_pixel, '0);
         end else begin
            want_result = blend_q.pop_front();
            in_flight--;
            if (got_result.pixel !== want_result.pixel)
               report_mismatch("out_pixel", got_result.pixel, want_result.pixel);
            if (got_result.written !== want_result.written)
               report_mismatch("written", 16'(got_result.written), 16'(want_result.written));
         end
      end
   end

   task automatic write_regs(input reg_write_type writes[$]);
      foreach (writes[i]) begin
         csr_valid <= 1'b1;
         csr_index <= writes[i].index;
         csr_data <= writes[i].data;
         do @(posedge clock); while (!csr_ready);
         apply_reg(writes[i].index, writes[i].data);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pixel_q.size() != 0 || in_flight != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_pair(input logic [PIXEL_WIDTH-1:0] src, input logic [PIXEL_WIDTH-1:0] dst);
      pixel_pair_type p;
      p.src = src;
      p.dst = dst;
      pixel_q.push_back(p);
   endtask

   function automatic logic [PIXEL_WIDTH-1:0] pick_pixel(input int key_pct);
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < key_pct)
         return key_color_q;
      if (roll < key_pct + 12) begin
         case ($urandom_range(4, 0))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'hF81F;
            3: return 16'h07E0;
            default: return key_color_q ^ (16'h1 << $urandom_range(15, 0));
         endcase
      end
      return 16'($urandom);
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_opacity();
      logic [6:0] v;
      case ($urandom_range(6, 0))
         0: v = 7'd0;
         1: v = 7'd100;
         2: v = 7'd127;
         3: v = 7'($urandom_range(3, 1));
         4: v = 7'($urandom_range(99, 97));
         5: v = 7'($urandom_range(127, 101));
         default: v = 7'($urandom_range(100, 0));
      endcase
      return {9'($urandom), v};
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_shade();
      logic [5:0] v;
      case ($urandom_range(5, 0))
         0: v = 6'd0;
         1: v = 6'd1;
         2: v = 6'd2;
         3: v = 6'd63;
         default: v = 6'($urandom_range(63, 0));
      endcase
      return {10'($urandom), v};
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_key_color();
      case ($urandom_range(4, 0))
         0: return KEY_COLOR_RESET;
         1: return 16'h0000;
         2: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      reg_write_type writes[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: full opacity, no shade, key 0xF81F enabled
      push_pair(16'hF81F, 16'h1234);
      push_pair(16'h0000, 16'hFFFF);
      push_pair(16'hFFFF, 16'h0000);
      push_pair(16'h07E0, 16'hF81F);
      push_pair(16'hF81E, 16'h0001);
      wait_idle();

      // opacity masks to zero, key disabled with source equal to key
      writes = '{'{CSR_OPACITY, 16'hFF80}, '{CSR_SHADE, 16'h0002},
                 '{CSR_KEY_ENABLE, 16'h0000}, '{CSR_KEY_COLOR, 16'h0000}};
      write_regs(writes);
      push_pair(16'h0000, 16'hABCD);
      push_pair(16'hFFFF, 16'h5555);
      wait_idle();

      // opacity saturates, largest shade, white keyed
      writes = '{'{CSR_OPACITY, 16'h007F}, '{CSR_SHADE, 16'h003F},
                 '{CSR_KEY_ENABLE, 16'hFFFF}, '{CSR_KEY_COLOR, 16'hFFFF}};
      write_regs(writes);
      push_pair(16'hFFFF, 16'h0000);
      push_pair(16'hFFFE, 16'h0000);
      push_pair(16'hF800, 16'h07E0);
      wait_idle();

      // half blend, shade of one, writes to unused indexes ignored
      writes = '{'{CSR_OPACITY, 16'd50}, '{CSR_SHADE, 16'hFFC1},
                 '{CSR_KEY_COLOR, 16'h8000}, '{CSR_TOP, 16'hFFFF},
                 '{CSR_LAST + 4'd1, 16'h0000}};
      write_regs(writes);
      push_pair(16'hFFFF, 16'h0000);
      push_pair(16'h0000, 16'hFFFF);
      push_pair(16'h8000, 16'h1234);
      push_pair(16'h7FFF, 16'hFFFF);
      wait_idle();

      // opacity just below one alpha step, shade two
      writes = '{'{CSR_OPACITY, 16'd3}, '{CSR_SHADE, 16'd2}};
      write_regs(writes);
      push_pair(16'hFFFF, 16'h0000);
      wait_idle();

      writes = '{'{CSR_OPACITY, 16'd97}, '{CSR_SHADE, 16'd0}};
      write_regs(writes);
      push_pair(16'hFFFF, 16'h0000);
      push_pair(16'h0000, 16'hFFFF);
      wait_idle();

      writes = '{'{CSR_OPACITY, 16'd4}};
      write_regs(writes);
      push_pair(16'hFFFF, 16'h0000);
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase / (RANDOM_PHASES / 3))
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         writes = '{'{CSR_OPACITY, pick_opacity()}, '{CSR_SHADE, pick_shade()},
                    '{CSR_KEY_ENABLE, CSR_DATA_WIDTH'($urandom)},
                    '{CSR_KEY_COLOR, pick_key_color()}};
         if ($urandom_range(2, 0) == 0)
            writes.push_back('{4'($urandom_range(CSR_TOP, CSR_LAST + 1)),
                               CSR_DATA_WIDTH'($urandom)});
         write_regs(writes);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            push_pair(pick_pixel(20), pick_pixel(0));
         wait_idle();
      end

      while (blend_q.size() != 0) begin
         want_result = blend_q.pop_front();
         report_mismatch("missing response", '0, want_result.pixel);
      end
      if (error_count == 0)
         $display("rgb565_alpha_shade_blend regression: pass");
      else
         $display("rgb565_alpha_shade_blend regression: fail");
      $finish;
   end

endmodule
